// ----- src/tct_pkg.sv -----
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants for the fault code table.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int ENTRIES   = 32;
  localparam int LOG_SLOTS = 16;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LS_W  = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;

  // live counter saturates at the table size or 63
  localparam logic [5:0] LIVE_CAP = 6'((ENTRIES < 63) ? ENTRIES : 63);

  localparam logic [15:0] THR_RST   = 16'd3;
  localparam logic [31:0] AGE_RST   = 32'd60000;
  localparam logic [7:0]  CRIT_LO_RST = 8'd1;
  localparam logic [7:0]  CRIT_HI_RST = 8'd10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LS_W-1:0]  lslot_t;

  typedef enum logic [2:0] {
    OP_LOG    = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_CLRALL = 3'd3,
    OP_AGE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADCODE  = 2'd3
  } res_code_t;

  typedef enum logic [1:0] {
    ES_EMPTY     = 2'd0,
    ES_PENDING   = 2'd1,
    ES_CONFIRMED = 2'd2,
    ES_CLEARED   = 2'd3
  } estate_t;

  typedef enum logic [1:0] {
    CFG_THR     = 2'd0,
    CFG_AGE     = 2'd1,
    CFG_CRIT_LO = 2'd2,
    CFG_CRIT_HI = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN1,
    FSM_SCAN2,
    FSM_FIN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [7:0]  code;
    estate_t     state;
    logic [15:0] count;
    logic [31:0] time_ms;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
  } entry_t;

  typedef struct packed {
    logic live;
    logic free;
  } cell_flags_t;

endpackage

// ----- src/trouble_code_table.sv -----
// ----------------------------------------------------------------------------
// trouble_code_table
// Fault code table with log, lookup, clear one, clear all and aging.
// ----------------------------------------------------------------------------
// The table is a ring of ENTRIES cells that rotates one place per cycle while
// an operation scans, past a single edit point, so every scan visits the
// entries in order, one entry a cycle. An accepted transaction with a valid code
// makes one full turn of the ring, or a second turn for a log that has to claim a new slot,
// since the free slot is only known after a full turn; a rejected code skips
// the scan. The block takes one transaction at a time and is ready again in the
// cycle after its result is taken. Configuration writes are accepted at any
// time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module trouble_code_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_fault_code,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_arg_one,
  input  logic [31:0] in_arg_two,
  input  logic [31:0] in_arg_three,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_status,
  output logic [1:0]  out_entry_state,
  output logic [15:0] out_occurrences,
  output logic [31:0] out_entry_time,
  output logic [31:0] out_entry_arg_one,
  output logic [31:0] out_entry_arg_two,
  output logic [31:0] out_entry_arg_three,
  output logic [5:0]  out_active_count,
  output logic        out_safe_state,
  output logic [31:0] out_total_errors,
  output logic        out_log_write,
  output logic [3:0]  out_log_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tct_pkg::*;

  entry_t      cell_q [ENTRIES];
  cell_flags_t cell_f [ENTRIES];
  entry_t      tail;
  logic        shift_en;

  // cell k takes from cell k+1; the last cell takes the edited head
  for (genvar k = 0; k < ENTRIES; k++) begin : g_ring
    entry_t d;
    if (k == ENTRIES - 1) begin : g_last
      assign d = tail;
    end else begin : g_mid
      assign d = cell_q[k+1];
    end
    tct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (d),
      .q        (cell_q[k]),
      .flags    (cell_f[k])
    );
  end

  tct_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_fault_code       (in_fault_code),
    .in_now_ms           (in_now_ms),
    .in_arg_one          (in_arg_one),
    .in_arg_two          (in_arg_two),
    .in_arg_three        (in_arg_three),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_status   (out_result_status),
    .out_entry_state     (out_entry_state),
    .out_occurrences     (out_occurrences),
    .out_entry_time      (out_entry_time),
    .out_entry_arg_one   (out_entry_arg_one),
    .out_entry_arg_two   (out_entry_arg_two),
    .out_entry_arg_three (out_entry_arg_three),
    .out_active_count    (out_active_count),
    .out_safe_state      (out_safe_state),
    .out_total_errors    (out_total_errors),
    .out_log_write       (out_log_write),
    .out_log_slot        (out_log_slot),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .head                (cell_q[0]),
    .head_flags          (cell_f[0]),
    .tail                (tail),
    .shift_en            (shift_en)
  );

endmodule

// ----- src/tct_cell.sv -----
// ----------------------------------------------------------------------------
// tct_cell
// One table entry in the rotating ring; reports whether it is live or free.
// ----------------------------------------------------------------------------
module tct_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  tct_pkg::entry_t      d,
  output tct_pkg::entry_t      q,
  output tct_pkg::cell_flags_t flags
);
  import tct_pkg::*;

  logic [7:0]  code_r;
  estate_t     state_r;
  logic [15:0] count_r;
  logic [31:0] time_r;
  logic [31:0] a1_r;
  logic [31:0] a2_r;
  logic [31:0] a3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r  <= '0;
      state_r <= ES_EMPTY;
      count_r <= '0;
    end else if (shift_en) begin
      code_r  <= d.code;
      state_r <= d.state;
      count_r <= d.count;
    end
  end

  // payload only, always written when a slot is claimed
  always_ff @(posedge clk) begin
    if (shift_en) begin
      time_r <= d.time_ms;
      a1_r   <= d.a1;
      a2_r   <= d.a2;
      a3_r   <= d.a3;
    end
  end

  assign q = '{code: code_r, state: state_r, count: count_r, time_ms: time_r,
               a1: a1_r, a2: a2_r, a3: a3_r};

  assign flags.live = (state_r == ES_PENDING) || (state_r == ES_CONFIRMED);
  assign flags.free = (state_r == ES_EMPTY) || (state_r == ES_CLEARED);

endmodule

// ----- src/tct_ctrl.sv -----
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer: rotates the ring, edits the entry at the head, builds results.
// ----------------------------------------------------------------------------
module tct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_operation,
  input  logic [7:0]           in_fault_code,
  input  logic [31:0]          in_now_ms,
  input  logic [31:0]          in_arg_one,
  input  logic [31:0]          in_arg_two,
  input  logic [31:0]          in_arg_three,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_status,
  output logic [1:0]           out_entry_state,
  output logic [15:0]          out_occurrences,
  output logic [31:0]          out_entry_time,
  output logic [31:0]          out_entry_arg_one,
  output logic [31:0]          out_entry_arg_two,
  output logic [31:0]          out_entry_arg_three,
  output logic [5:0]           out_active_count,
  output logic                 out_safe_state,
  output logic [31:0]          out_total_errors,
  output logic                 out_log_write,
  output logic [3:0]           out_log_slot,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  tct_pkg::entry_t      head,
  input  tct_pkg::cell_flags_t head_flags,
  output tct_pkg::entry_t      tail,
  output logic                 shift_en
);
  import tct_pkg::*;

  fsm_t        st_r, st_nxt;
  op_t         op_r, op_nxt;
  logic        bad_r, bad_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] a1_r, a1_nxt, a2_r, a2_nxt, a3_r, a3_nxt;
  idx_t        idx_r, idx_nxt;
  logic        found_r, found_nxt;
  logic        ffound_r, ffound_nxt;
  idx_t        fidx_r, fidx_nxt;
  entry_t      tch_r, tch_nxt;
  logic [5:0]  live_r, live_nxt;
  logic [31:0] total_r, total_nxt;
  logic        safe_r, safe_nxt;
  lslot_t      nls_r, nls_nxt;

  logic [15:0] thr_r;
  logic [31:0] age_lim_r;
  logic [7:0]  crit_lo_r, crit_hi_r;

  logic        ov_r, ov_nxt;
  res_code_t   o_status_r, o_status_nxt;
  entry_t      o_ent_r, o_ent_nxt;
  logic [5:0]  o_live_r, o_live_nxt;
  logic        o_safe_r, o_safe_nxt;
  logic [31:0] o_total_r, o_total_nxt;
  logic        o_lw_r, o_lw_nxt;
  lslot_t      o_slot_r, o_slot_nxt;

  entry_t      nw;
  logic        hit_here;
  logic        match;
  logic        last;
  logic [15:0] cnt_inc;
  logic [31:0] age;
  logic        in_bad;
  op_t         in_op;

  assign in_op  = op_t'(in_operation);
  assign in_bad = ((in_operation <= 3'(OP_CLEAR)) && (in_fault_code == 8'd0)) ||
                  (in_operation > 3'(OP_AGE));
  assign last   = (idx_r == idx_t'(ENTRIES - 1));
  assign match  = !found_r && head_flags.live && (head.code == code_r);
  assign cnt_inc = (head.count == 16'hFFFF) ? head.count : head.count + 16'd1;
  assign age    = now_r - head.time_ms;

  assign in_ready  = (st_r == FSM_IDLE);
  assign cfg_ready = 1'b1;
  assign shift_en  = (st_r == FSM_SCAN1) || (st_r == FSM_SCAN2);
  assign tail      = nw;

  // head edit
  always_comb begin
    nw       = head;
    hit_here = 1'b0;
    if (st_r == FSM_SCAN1) begin
      case (op_r)
        OP_LOG: if (match) begin
          hit_here   = 1'b1;
          nw.count   = cnt_inc;
          nw.time_ms = now_r;
          nw.a1      = a1_r;
          nw.a2      = a2_r;
          nw.a3      = a3_r;
          if (cnt_inc >= thr_r) nw.state = ES_CONFIRMED;
        end
        OP_LOOKUP: hit_here = match;
        OP_CLEAR: if (match) begin
          hit_here = 1'b1;
          nw.state = ES_CLEARED;
        end
        OP_CLRALL: if (head_flags.live) nw.state = ES_CLEARED;
        OP_AGE: if (head.state == ES_PENDING && age > age_lim_r) begin
          nw.state = ES_EMPTY;
          nw.code  = 8'd0;
        end
        default: ;
      endcase
    end else if (st_r == FSM_SCAN2 && idx_r == fidx_r) begin
      hit_here = 1'b1;
      nw = '{code: code_r, state: ES_PENDING, count: 16'd1, time_ms: now_r,
             a1: a1_r, a2: a2_r, a3: a3_r};
    end
  end

  always_comb begin
    st_nxt = st_r;   op_nxt = op_r;   bad_nxt = bad_r;  code_nxt = code_r;
    now_nxt = now_r; a1_nxt = a1_r;   a2_nxt = a2_r;    a3_nxt = a3_r;
    idx_nxt = idx_r; found_nxt = found_r; ffound_nxt = ffound_r;
    fidx_nxt = fidx_r; tch_nxt = tch_r; live_nxt = live_r;
    total_nxt = total_r; safe_nxt = safe_r; nls_nxt = nls_r;
    ov_nxt = ov_r; o_status_nxt = o_status_r; o_ent_nxt = o_ent_r;
    o_live_nxt = o_live_r; o_safe_nxt = o_safe_r; o_total_nxt = o_total_r;
    o_lw_nxt = o_lw_r; o_slot_nxt = o_slot_r;

    case (st_r)
      FSM_IDLE: if (in_valid) begin
        op_nxt     = in_op;
        bad_nxt    = in_bad;
        code_nxt   = in_fault_code;
        now_nxt    = in_now_ms;
        a1_nxt     = in_arg_one;
        a2_nxt     = in_arg_two;
        a3_nxt     = in_arg_three;
        idx_nxt    = '0;
        found_nxt  = 1'b0;
        ffound_nxt = 1'b0;
        st_nxt     = in_bad ? FSM_FIN : FSM_SCAN1;
      end
      FSM_SCAN1: begin
        idx_nxt = idx_r + idx_t'(1);
        if (hit_here) begin
          found_nxt = 1'b1;
          tch_nxt   = nw;
        end
        if (!ffound_r && head_flags.free) begin
          ffound_nxt = 1'b1;
          fidx_nxt   = idx_r;
        end
        if (op_r == OP_AGE && head.state == ES_PENDING && age > age_lim_r &&
            live_r != 6'd0)
          live_nxt = live_r - 6'd1;
        if (last) begin
          idx_nxt = '0;
          st_nxt  = (op_r == OP_LOG && !found_nxt && ffound_nxt) ? FSM_SCAN2 : FSM_FIN;
        end
      end
      FSM_SCAN2: begin
        idx_nxt = idx_r + idx_t'(1);
        if (hit_here) begin
          found_nxt = 1'b1;
          tch_nxt   = nw;
          if (live_r < LIVE_CAP) live_nxt = live_r + 6'd1;
        end
        if (last) begin
          idx_nxt = '0;
          st_nxt  = FSM_FIN;
        end
      end
      FSM_FIN: begin
        o_lw_nxt   = 1'b0;
        o_slot_nxt = '0;
        if (bad_r) o_status_nxt = ST_BADCODE;
        else begin
          case (op_r)
            OP_LOG:    o_status_nxt = found_r ? ST_OK : ST_FULL;
            OP_LOOKUP: o_status_nxt = found_r ? ST_OK : ST_NOTFOUND;
            OP_CLEAR:  o_status_nxt = found_r ? ST_OK : ST_NOTFOUND;
            default:   o_status_nxt = ST_OK;
          endcase
          if (op_r == OP_CLRALL) live_nxt = 6'd0;
          if (op_r == OP_LOG) begin
            total_nxt = total_r + 32'd1;
            if (code_r >= crit_lo_r && code_r <= crit_hi_r) safe_nxt = 1'b1;
            if (found_r && tch_r.state == ES_CONFIRMED) begin
              o_lw_nxt   = 1'b1;
              o_slot_nxt = nls_r;
              nls_nxt    = (nls_r == lslot_t'(LOG_SLOTS - 1)) ? '0 : nls_r + lslot_t'(1);
            end
          end
        end
        o_ent_nxt   = found_r ? tch_r : '0;
        o_live_nxt  = live_nxt;
        o_safe_nxt  = safe_nxt;
        o_total_nxt = total_nxt;
        ov_nxt      = 1'b1;
        st_nxt      = FSM_DONE;
      end
      FSM_DONE: if (out_ready) begin
        ov_nxt = 1'b0;
        st_nxt = FSM_IDLE;
      end
      default: st_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= FSM_IDLE;
      ov_r    <= 1'b0;
      live_r  <= '0;
      total_r <= '0;
      safe_r  <= 1'b0;
      nls_r   <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
      ffound_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
      live_r  <= live_nxt;
      total_r <= total_nxt;
      safe_r  <= safe_nxt;
      nls_r   <= nls_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      ffound_r <= ffound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;   bad_r <= bad_nxt; code_r <= code_nxt; now_r <= now_nxt;
    a1_r   <= a1_nxt;   a2_r  <= a2_nxt;  a3_r   <= a3_nxt;
    fidx_r <= fidx_nxt; tch_r <= tch_nxt;
    o_status_r <= o_status_nxt; o_ent_r <= o_ent_nxt; o_live_r <= o_live_nxt;
    o_safe_r   <= o_safe_nxt;   o_total_r <= o_total_nxt;
    o_lw_r     <= o_lw_nxt;     o_slot_r  <= o_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RST;
      age_lim_r <= AGE_RST;
      crit_lo_r <= CRIT_LO_RST;
      crit_hi_r <= CRIT_HI_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THR:     thr_r     <= cfg_data[15:0];
        CFG_AGE:     age_lim_r <= cfg_data;
        CFG_CRIT_LO: crit_lo_r <= cfg_data[7:0];
        CFG_CRIT_HI: crit_hi_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid           = ov_r;
  assign out_result_status   = o_status_r;
  assign out_entry_state     = o_ent_r.state;
  assign out_occurrences     = o_ent_r.count;
  assign out_entry_time      = o_ent_r.time_ms;
  assign out_entry_arg_one   = o_ent_r.a1;
  assign out_entry_arg_two   = o_ent_r.a2;
  assign out_entry_arg_three = o_ent_r.a3;
  assign out_active_count    = o_live_r;
  assign out_safe_state      = o_safe_r;
  assign out_total_errors    = o_total_r;
  assign out_log_write       = o_lw_r;
  assign out_log_slot        = 4'(o_slot_r);

endmodule
